// File: sv/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is high
`define PRR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// Concurrent check that also runs across reset
`define PRR_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");

`endif

// File: sv/prr_pkg.sv
// Shared types, constants and helper functions of the polar/rectangular unit.
// No dependencies; imported by every module of the block.
package prr_pkg;

   localparam int CORDIC_STEPS    = 16;  // rotation stages
   localparam int COORD_FRAC_BITS = 8;   // Q15.8 coordinates (format name only)
   localparam int COORD_W         = 24;
   localparam int ANGLE_IN_W      = 20;
   localparam int SIZE_W          = 23;
   localparam int GUARD           = 8;
   localparam int VEC_W           = 35;  // guarded vector incl. CORDIC growth
   localparam int ANG_W           = 30;  // Q.24 internal angle
   localparam int SAT_W           = 30;
   localparam int PRE_W           = 25;  // coordinate after negation

   localparam logic signed [ANG_W-1:0] PI_Q24     = 30'sd52707179;
   localparam logic signed [ANG_W-1:0] TWO_PI_Q24 = 30'sd105414358;
   localparam logic signed [ANG_W-1:0] HALFPI_Q24 = 30'sd26353589;
   localparam logic signed [24:0]      KINV_Q24   = 25'sd10188014;

   // exact axis angles, Q3.16 rounded
   localparam logic signed [COORD_W-1:0] ANG_POS_HALF = 24'sd102944;
   localparam logic signed [COORD_W-1:0] ANG_NEG_HALF = -24'sd102944;
   localparam logic signed [COORD_W-1:0] ANG_PI       = 24'sd205887;
   localparam logic signed [21:0]        ANG_MIN_Q16  = -22'sd102944;
   localparam logic signed [21:0]        ANG_MAX_Q16  = 22'sd308830;

   localparam logic signed [COORD_W-1:0] OUT_MAX = 24'sd8388607;
   localparam logic signed [COORD_W-1:0] OUT_MIN = -24'sd8388608;

   typedef enum logic [1:0] {
      MODE_POLAR  = 2'd0,
      MODE_RECT   = 2'd1,
      MODE_OFFSET = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   // side data that rides along the pipeline
   typedef struct packed {
      mode_type                    mode;
      logic                        spec;  // polar request on an axis
      logic                        vec;   // vectoring direction rule
      logic signed [COORD_W-1:0]   pa;    // position x, or axis radius
      logic signed [COORD_W-1:0]   pb;    // position y, or axis angle
   } ctl_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ANG_W-1:0] z;
   } cdata_type;

   // atan(2^-i) in Q.24
   function automatic logic signed [ANG_W-1:0] atan_step(input int unsigned i);
      logic signed [ANG_W-1:0] r;
      unique case (i)
         0:       r = 30'sd13176795;
         1:       r = 30'sd7778716;
         2:       r = 30'sd4110060;
         3:       r = 30'sd2086331;
         4:       r = 30'sd1047214;
         5:       r = 30'sd524117;
         6:       r = 30'sd262139;
         7:       r = 30'sd131069;
         default: r = ANG_W'(64'd1 << (24 - i));
      endcase
      return r;
   endfunction

   function automatic logic signed [COORD_W-1:0] sat_coord(
      input logic signed [SAT_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > SAT_W'(OUT_MAX)) r = OUT_MAX;
      else if (v < SAT_W'(OUT_MIN)) r = OUT_MIN;
      else r = v[COORD_W-1:0];
      return r;
   endfunction

endpackage

// File: sv/polar_rect_rotate_unit.sv
// Top level of the polar/rectangular conversion and rotate unit.
// Depends on prr_pkg, prr_prep, prr_cordic and prr_post.
//
// Usage:
//   Request channel (req_*): one request per accepted beat. req_tuser holds
//   the mode: 0 rectangular to polar, 1 polar to rectangular, 2 position
//   minus the rotated half-size vector, 3 gives zeros.
//   Result channel (rsp_*): exactly one result per request, in order.
// Pipeline: a result shows on rsp_tvalid after its request has passed
//   2 conditioning stages, one stage per CORDIC step (16) and 3 output
//   stages: split gain multiply, rounding, saturation/result register.
// Throughput: one request per cycle unless a result stalls; every stage
//   holds one request and the pipeline moves as a whole.
// Stall: when rsp_tvalid is high and rsp_tready low, every stage holds and
//   req_tready drops in the same cycle; nothing is lost or repeated.
// Reset: synchronous, active high; clears all valid bits, so the pipeline
//   comes up empty and ready.
module polar_rect_rotate_unit import prr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [23:0] coord_x, [47:24] coord_y, [67:48] angle_in,
   // [90:68] size_w, [113:91] size_h, [119:114] zero
   input  logic [119:0] req_tdata,
   // [1:0] mode
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [23:0] out_first, [47:24] out_second
   output logic [47:0]  rsp_tdata
);

   logic      adv;
   logic      p_vld, c_vld, o_vld;
   ctl_type   p_ctl, c_ctl;
   cdata_type p_data, c_data;
   logic signed [COORD_W-1:0] out_first, out_second;

   // whole pipeline advances unless a result sits unread
   assign adv        = !o_vld || rsp_tready;
   assign req_tready = adv;

   prr_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .vld_in   (req_tvalid),
      .mode     (mode_type'(req_tuser)),
      .coord_x  ($signed(req_tdata[23:0])),
      .coord_y  ($signed(req_tdata[47:24])),
      .angle_in ($signed(req_tdata[67:48])),
      .size_w   (req_tdata[90:68]),
      .size_h   (req_tdata[113:91]),
      .vld_out  (p_vld),
      .ctl_out  (p_ctl),
      .data_out (p_data)
   );

   prr_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .vld_in   (p_vld),
      .ctl_in   (p_ctl),
      .data_in  (p_data),
      .vld_out  (c_vld),
      .ctl_out  (c_ctl),
      .data_out (c_data)
   );

   prr_post u_post (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .vld_in     (c_vld),
      .ctl_in     (c_ctl),
      .data_in    (c_data),
      .vld_out    (o_vld),
      .out_first  (out_first),
      .out_second (out_second)
   );

   assign rsp_tvalid = o_vld;
   assign rsp_tdata  = {out_second, out_first};

endmodule

// File: sv/prr_prep.sv
// Input conditioning: angle reduction, axis cases, quadrant fold (2 stages).
// Depends on prr_pkg.
module prr_prep import prr_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          vld_in,
   input  mode_type                      mode,
   input  logic signed [COORD_W-1:0]     coord_x,
   input  logic signed [COORD_W-1:0]     coord_y,
   input  logic signed [ANGLE_IN_W-1:0]  angle_in,
   input  logic [SIZE_W-1:0]             size_w,
   input  logic [SIZE_W-1:0]             size_h,
   output logic                          vld_out,
   output ctl_type                       ctl_out,
   output cdata_type                     data_out
);

   logic                      a_vld_ff;
   ctl_type                   a_ctl_ff, a_ctl_in;
   logic signed [PRE_W-1:0]   a_x_ff, a_x_in, a_y_ff, a_y_in;
   logic signed [ANG_W-1:0]   a_z_ff, a_z_in;

   logic                      b_vld_ff;
   ctl_type                   b_ctl_ff;
   cdata_type                 b_data_ff, b_data_in;

   // stage A: reduce angle modulo 2pi, handle axis vectors, pick operands
   always_comb begin
      logic signed [ANG_W-1:0] zr;
      logic signed [PRE_W-1:0] ax, ay;
      zr = ANG_W'(angle_in) <<< 8;
      for (int k = 0; k < 3; k++) begin
         if (zr > PI_Q24) zr = zr - TWO_PI_Q24;
         else if (zr < -PI_Q24) zr = zr + TWO_PI_Q24;
      end
      ax = coord_x[COORD_W-1] ? -PRE_W'(coord_x) : PRE_W'(coord_x);
      ay = coord_y[COORD_W-1] ? -PRE_W'(coord_y) : PRE_W'(coord_y);
      a_ctl_in.mode = mode;
      a_ctl_in.vec  = (mode == MODE_POLAR);
      a_ctl_in.spec = 1'b0;
      a_ctl_in.pa   = coord_x;
      a_ctl_in.pb   = coord_y;
      a_x_in = PRE_W'(coord_x);
      a_y_in = PRE_W'(coord_y);
      a_z_in = zr;
      unique case (mode)
         MODE_POLAR: begin
            a_z_in = '0;
            if (coord_x == '0) begin
               a_ctl_in.spec = 1'b1;
               a_ctl_in.pa   = sat_coord(SAT_W'(ay));
               a_ctl_in.pb   = (coord_y == '0) ? '0 :
                               (coord_y[COORD_W-1] ? ANG_NEG_HALF : ANG_POS_HALF);
            end else if (coord_y == '0) begin
               a_ctl_in.spec = 1'b1;
               a_ctl_in.pa   = sat_coord(SAT_W'(ax));
               a_ctl_in.pb   = coord_x[COORD_W-1] ? ANG_PI : '0;
            end else if (coord_x[COORD_W-1]) begin
               a_x_in = -PRE_W'(coord_x);
               a_y_in = -PRE_W'(coord_y);
               a_z_in = PI_Q24;
            end
         end
         MODE_RECT: begin
            a_y_in = '0;
         end
         MODE_OFFSET: begin
            a_x_in = PRE_W'(size_w);
            a_y_in = PRE_W'(size_h);
         end
         MODE_NONE: begin
            a_x_in = '0;
            a_y_in = '0;
         end
      endcase
   end

   // stage B: fold rotation angle into [-pi/2, pi/2], add guard bits
   always_comb begin
      logic signed [PRE_W-1:0] fx, fy;
      logic signed [ANG_W-1:0] fz;
      fx = a_x_ff;
      fy = a_y_ff;
      fz = a_z_ff;
      if (!a_ctl_ff.vec) begin
         if (a_z_ff > HALFPI_Q24) begin
            fz = a_z_ff - PI_Q24;
            fx = -a_x_ff;
            fy = -a_y_ff;
         end else if (a_z_ff < -HALFPI_Q24) begin
            fz = a_z_ff + PI_Q24;
            fx = -a_x_ff;
            fy = -a_y_ff;
         end
      end
      b_data_in.x = VEC_W'(fx) <<< GUARD;
      b_data_in.y = VEC_W'(fy) <<< GUARD;
      b_data_in.z = fz;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= vld_in;
         b_vld_ff <= a_vld_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         a_ctl_ff  <= a_ctl_in;
         a_x_ff    <= a_x_in;
         a_y_ff    <= a_y_in;
         a_z_ff    <= a_z_in;
         b_ctl_ff  <= a_ctl_ff;
         b_data_ff <= b_data_in;
      end
   end

   assign vld_out  = b_vld_ff;
   assign ctl_out  = b_ctl_ff;
   assign data_out = b_data_ff;

endmodule

// File: sv/prr_cordic.sv
// Unrolled CORDIC: one registered micro-rotation per stage.
// Depends on prr_pkg.
module prr_cordic import prr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      adv,
   input  logic      vld_in,
   input  ctl_type   ctl_in,
   input  cdata_type data_in,
   output logic      vld_out,
   output ctl_type   ctl_out,
   output cdata_type data_out
);

   logic      vld_ff  [CORDIC_STEPS];
   ctl_type   ctl_ff  [CORDIC_STEPS];
   cdata_type data_ff [CORDIC_STEPS];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic      v_src;
      ctl_type   c_src;
      cdata_type d_src;
      cdata_type d_in;

      if (i == 0) begin : g_first
         assign v_src = vld_in;
         assign c_src = ctl_in;
         assign d_src = data_in;
      end else begin : g_next
         assign v_src = vld_ff[i-1];
         assign c_src = ctl_ff[i-1];
         assign d_src = data_ff[i-1];
      end

      // rotation drives z to zero; vectoring drives y to zero
      always_comb begin
         logic pos;
         logic signed [VEC_W-1:0] xs, ys;
         pos = c_src.vec ? (d_src.y <= 0) : (d_src.z >= 0);
         xs  = d_src.x >>> i;
         ys  = d_src.y >>> i;
         if (pos) begin
            d_in.x = d_src.x - ys;
            d_in.y = d_src.y + xs;
            d_in.z = d_src.z - atan_step(i);
         end else begin
            d_in.x = d_src.x + ys;
            d_in.y = d_src.y - xs;
            d_in.z = d_src.z + atan_step(i);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (adv) begin
            vld_ff[i] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            ctl_ff[i]  <= c_src;
            data_ff[i] <= d_in;
         end
      end
   end

   assign vld_out  = vld_ff[CORDIC_STEPS-1];
   assign ctl_out  = ctl_ff[CORDIC_STEPS-1];
   assign data_out = data_ff[CORDIC_STEPS-1];

endmodule

// File: sv/prr_post.sv
// Gain removal, rounding, saturation and result selection (3 stages).
// Depends on prr_pkg.
module prr_post import prr_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      vld_in,
   input  ctl_type                   ctl_in,
   input  cdata_type                 data_in,
   output logic                      vld_out,
   output logic signed [COORD_W-1:0] out_first,
   output logic signed [COORD_W-1:0] out_second
);

   localparam int PROD_W = 43;
   localparam int SUM_W  = 60;
   localparam int RES_W  = 28;

   // stage 1: split products by 1/K
   logic                      m_vld_ff;
   ctl_type                   m_ctl_ff;
   logic signed [PROD_W-1:0]  m_hx_ff, m_lx_ff, m_hy_ff, m_ly_ff;
   logic signed [PROD_W-1:0]  m_hx_in, m_lx_in, m_hy_in, m_ly_in;
   logic signed [21:0]        m_ang_ff, m_ang_in;

   // stage 2: sums, rounding shift, angle clamp
   logic                      s_vld_ff;
   ctl_type                   s_ctl_ff;
   logic signed [RES_W-1:0]   s_rx_ff, s_rx_in, s_ry_ff, s_ry_in;
   logic signed [COORD_W-1:0] s_ang_ff, s_ang_in;

   // stage 3: result register
   logic                      o_vld_ff;
   logic signed [COORD_W-1:0] o_first_ff, o_first_in, o_second_ff, o_second_in;

   always_comb begin
      logic signed [VEC_W-1:0] xc;
      logic signed [ANG_W-1:0] zr;
      xc = (ctl_in.vec && data_in.x < 0) ? '0 : data_in.x;
      m_hx_in = PROD_W'($signed(xc[VEC_W-1:17]) * KINV_Q24);
      m_lx_in = PROD_W'($signed({1'b0, xc[16:0]}) * KINV_Q24);
      m_hy_in = PROD_W'($signed(data_in.y[VEC_W-1:17]) * KINV_Q24);
      m_ly_in = PROD_W'($signed({1'b0, data_in.y[16:0]}) * KINV_Q24);
      zr = data_in.z + ANG_W'(128);
      m_ang_in = zr[ANG_W-1:8];
   end

   always_comb begin
      logic signed [SUM_W-1:0] sx, sy, rnd;
      logic                    half;
      half = (m_ctl_ff.mode == MODE_OFFSET);
      rnd  = half ? (SUM_W'(1) <<< 32) : (SUM_W'(1) <<< 31);
      sx = $signed({m_hx_ff, 17'b0}) + SUM_W'(m_lx_ff) + rnd;
      sy = $signed({m_hy_ff, 17'b0}) + SUM_W'(m_ly_ff) + rnd;
      s_rx_in = half ? RES_W'(sx >>> 33) : sx[SUM_W-1:32];
      s_ry_in = half ? RES_W'(sy >>> 33) : sy[SUM_W-1:32];
      if (m_ang_ff < ANG_MIN_Q16) s_ang_in = COORD_W'(ANG_MIN_Q16);
      else if (m_ang_ff > ANG_MAX_Q16) s_ang_in = COORD_W'(ANG_MAX_Q16);
      else s_ang_in = COORD_W'(m_ang_ff);
   end

   always_comb begin
      unique case (s_ctl_ff.mode)
         MODE_POLAR: begin
            if (s_ctl_ff.spec) begin
               o_first_in  = s_ctl_ff.pa;
               o_second_in = s_ctl_ff.pb;
            end else begin
               o_first_in  = sat_coord(SAT_W'(s_rx_ff));
               o_second_in = s_ang_ff;
            end
         end
         MODE_RECT: begin
            o_first_in  = sat_coord(SAT_W'(s_rx_ff));
            o_second_in = sat_coord(SAT_W'(s_ry_ff));
         end
         MODE_OFFSET: begin
            o_first_in  = sat_coord(SAT_W'(s_ctl_ff.pa) - SAT_W'(s_rx_ff));
            o_second_in = sat_coord(SAT_W'(s_ctl_ff.pb) - SAT_W'(s_ry_ff));
         end
         MODE_NONE: begin
            o_first_in  = '0;
            o_second_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
         s_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else if (adv) begin
         m_vld_ff <= vld_in;
         s_vld_ff <= m_vld_ff;
         o_vld_ff <= s_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ctl_ff    <= ctl_in;
         m_hx_ff     <= m_hx_in;
         m_lx_ff     <= m_lx_in;
         m_hy_ff     <= m_hy_in;
         m_ly_ff     <= m_ly_in;
         m_ang_ff    <= m_ang_in;
         s_ctl_ff    <= m_ctl_ff;
         s_rx_ff     <= s_rx_in;
         s_ry_ff     <= s_ry_in;
         s_ang_ff    <= s_ang_in;
         o_first_ff  <= o_first_in;
         o_second_ff <= o_second_in;
      end
   end

   assign vld_out    = o_vld_ff;
   assign out_first  = o_first_ff;
   assign out_second = o_second_ff;

endmodule

// File: sv/prr_checker.sv
// Port-level checks of the polar/rectangular unit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module prr_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [47:0]  rsp_tdata
);

   // a stalled result stays and keeps its value
   `PRR_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   `PRR_ASSERT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
   // input side is ready exactly when the output register can move
   `PRR_ASSERT(a_ready_rule, clock, reset, req_tready == (!rsp_tvalid || rsp_tready))
   // pipeline comes out of reset empty
   `PRR_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid)

endmodule

bind polar_rect_rotate_unit prr_checker u_prr_checker (.*);

// File: dv/polar_rect_rotate_unit_test.sv
// Self-checking testbench of polar_rect_rotate_unit: directed table, then random requests.
// Depends on prr_pkg and the unit's RTL; results are written by hand or predicted by a local CORDIC model.
module polar_rect_rotate_unit_test import prr_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 40;
   localparam longint GAIN_INV   = 10188014;
   localparam longint PI_FIX     = 52707179;
   localparam longint HALFPI_FIX = 26353589;

   typedef struct {
      mode_type                   mode;
      logic signed [23:0]         cx;
      logic signed [23:0]         cy;
      logic signed [19:0]         ang;
      logic [22:0]                w;
      logic [22:0]                h;
      int                         phase;
      logic [23:0]                e_first;
      logic [23:0]                e_second;
   } request_item_type;

   typedef struct {
      logic [23:0] first;
      logic [23:0] second;
   } result_pair_type;

   // directed row: has_exp marks a hand-written expectation
   typedef struct {
      mode_type           mode;
      int                 cx;
      int                 cy;
      int                 ang;
      int                 w;
      int                 h;
      bit                 has_exp;
      int                 e_first;
      int                 e_second;
   } table_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [119:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [47:0]  rsp_tdata;

   request_item_type  pending_q[$];
   result_pair_type   expected_q[$];
   request_item_type  cur;
   int                cur_phase = 0;
   int                errors = 0;
   int                idle_count = 0;

   polar_rect_rotate_unit i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #1 clock = ~clock;

   // atan(2^-i) in Q.24
   function automatic longint arc_step(input int i);
      longint lut[8] = '{13176795, 7778716, 4110060, 2086331,
                         1047214, 524117, 262139, 131069};
      if (i < 8) return lut[i];
      return 64'sd1 <<< (24 - i);
   endfunction

   function automatic longint clamp24(input longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   // rotate (x0,y0) by a Q3.16 angle, output scaled by 2^-extra and rounded
   task automatic cordic_rotate(input longint x0, input longint y0, input longint ang,
                                input int extra, output longint ox, output longint oy);
      longint z, x, y, nx, ny;
      int sh;
      z = ang * 256;
      sh = 32 + extra;
      for (int k = 0; k < 3; k++) begin
         if (z > PI_FIX) z -= 2 * PI_FIX;
         else if (z < -PI_FIX) z += 2 * PI_FIX;
      end
      if (z > HALFPI_FIX) begin
         z -= PI_FIX; x0 = -x0; y0 = -y0;
      end else if (z < -HALFPI_FIX) begin
         z += PI_FIX; x0 = -x0; y0 = -y0;
      end
      x = x0 * 256;
      y = y0 * 256;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i); ny = y + (x >>> i); z -= arc_step(i);
         end else begin
            nx = x + (y >>> i); ny = y - (x >>> i); z += arc_step(i);
         end
         x = nx; y = ny;
      end
      ox = (x * GAIN_INV + (64'sd1 <<< (sh - 1))) >>> sh;
      oy = (y * GAIN_INV + (64'sd1 <<< (sh - 1))) >>> sh;
   endtask

   // vectoring mode: radius and angle, axes handled exactly
   task automatic cordic_polar(input longint x, input longint y,
                               output longint rad, output longint ang);
      longint z, vx, vy, nx, ny, r;
      z = 0;
      if (x == 0) begin
         rad = clamp24(y < 0 ? -y : y);
         ang = y > 0 ? (HALFPI_FIX + 128) >>> 8 : (y < 0 ? (-HALFPI_FIX + 128) >>> 8 : 0);
         return;
      end
      if (y == 0) begin
         rad = clamp24(x < 0 ? -x : x);
         ang = x < 0 ? (PI_FIX + 128) >>> 8 : 0;
         return;
      end
      if (x < 0) begin
         x = -x; y = -y; z = PI_FIX;
      end
      vx = x * 256;
      vy = y * 256;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (vy > 0) begin
            nx = vx + (vy >>> i); ny = vy - (vx >>> i); z += arc_step(i);
         end else begin
            nx = vx - (vy >>> i); ny = vy + (vx >>> i); z -= arc_step(i);
         end
         vx = nx; vy = ny;
      end
      if (vx < 0) vx = 0;
      r = (vx * GAIN_INV + (64'sd1 <<< 31)) >>> 32;
      rad = r > 8388607 ? 8388607 : r;
      ang = (z + 128) >>> 8;
      if (ang < -102944) ang = -102944;
      if (ang > 308830) ang = 308830;
   endtask

   task automatic predict_result(inout request_item_type it);
      longint f, s, rx, ry;
      f = 0; s = 0;
      case (it.mode)
         MODE_POLAR: begin
            cordic_polar(longint'(it.cx), longint'(it.cy), f, s);
         end
         MODE_RECT: begin
            cordic_rotate(longint'(it.cx), 0, longint'(it.ang), 0, rx, ry);
            f = clamp24(rx); s = clamp24(ry);
         end
         MODE_OFFSET: begin
            cordic_rotate(longint'({1'b0, it.w}), longint'({1'b0, it.h}),
                          longint'(it.ang), 1, rx, ry);
            f = clamp24(longint'(it.cx) - rx);
            s = clamp24(longint'(it.cy) - ry);
         end
         default: begin
            f = 0; s = 0;
         end
      endcase
      it.e_first = f[23:0];
      it.e_second = s[23:0];
   endtask

   // random coordinate: full range, scaled down, or an extreme
   function automatic logic [23:0] rand_coord();
      logic signed [23:0] v;
      v = 24'($urandom);
      case ($urandom_range(3))
         0: return v;
         1: return v >>> $urandom_range(23);
         2: return $urandom_range(1) ? 24'h7fffff : 24'h800000;
         default: return v >>> $urandom_range(8, 16);
      endcase
   endfunction

   function automatic logic [22:0] rand_size();
      logic [22:0] v;
      v = 23'($urandom);
      case ($urandom_range(3))
         0: return v;
         1: return v >> $urandom_range(22);
         2: return $urandom_range(1) ? 23'h7fffff : 23'h0;
         default: return v >> $urandom_range(8, 16);
      endcase
   endfunction

   task automatic report_mismatch(input string field, input logic [23:0] got,
                                  input logic [23:0] want);
      errors++;
      $display("mismatch %s: got %0d expected %0d at %0t",
               field, $signed(got), $signed(want), $realtime);
   endtask

   // request side: record accepted requests, launch the next one
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_q.push_back('{cur.e_first, cur.e_second});
         if (!req_tvalid || req_tready) begin
            if (pending_q.size() > 0 &&
                !((pending_q[0].phase == 1 && $urandom_range(99) < 72) ||
                  (pending_q[0].phase == 3 && $urandom_range(99) < 7))) begin
               cur = pending_q.pop_front();
               cur_phase = cur.phase;
               req_tvalid <= 1'b1;
               req_tdata <= {6'b0, cur.h, cur.w, cur.ang, cur.cy, cur.cx};
               req_tuser <= cur.mode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result side: random stalls and the field compare
   always @(posedge clock) begin
      result_pair_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata[23:0], 24'd0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_tdata[23:0] !== want.first)
                  report_mismatch("out_first", rsp_tdata[23:0], want.first);
               if (rsp_tdata[47:24] !== want.second)
                  report_mismatch("out_second", rsp_tdata[47:24], want.second);
            end
         end
         if (cur_phase == 2) rsp_tready <= $urandom_range(99) >= 72;
         else if (cur_phase == 3) rsp_tready <= $urandom_range(99) >= 7;
         else rsp_tready <= 1'b1;
      end
   end

   // watchdog on cycles without any handshake while work is outstanding
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (pending_q.size() == 0 && expected_q.size() == 0 && !req_tvalid)) begin
         idle_count <= 0;
      end else if (idle_count >= WATCHDOG_LIMIT) begin
         $display("[polar_rect_rotate_unit] ERROR");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   initial begin
      table_row_type    rows[$];
      request_item_type it;
      // zero vector, axes, saturation, unused mode, then predicted extremes
      rows = '{
         '{MODE_POLAR, 0, 0, 0, 0, 0, 1, 0, 0},
         '{MODE_POLAR, 100, 0, 0, 0, 0, 1, 100, 0},
         '{MODE_POLAR, 0, 5, 0, 0, 0, 1, 5, 102944},
         '{MODE_POLAR, 0, -5, 0, 0, 0, 1, 5, -102944},
         '{MODE_POLAR, -7, 0, 0, 0, 0, 1, 7, 205887},
         '{MODE_POLAR, 0, -8388608, 0, 0, 0, 1, 8388607, -102944},
         '{MODE_POLAR, -8388608, 0, 0, 0, 0, 1, 8388607, 205887},
         '{MODE_NONE, 8388607, -8388608, 524287, 8388607, 8388607, 1, 0, 0},
         '{MODE_POLAR, 8388607, 8388607, 0, 0, 0, 0, 0, 0},
         '{MODE_POLAR, -8388608, -8388608, 0, 0, 0, 0, 0, 0},
         '{MODE_POLAR, -3, 8388607, 0, 0, 0, 0, 0, 0},
         '{MODE_POLAR, 1, -1, 0, 0, 0, 0, 0, 0},
         '{MODE_RECT, 8388607, 0, 0, 0, 0, 0, 0, 0},
         '{MODE_RECT, -8388608, 0, 524287, 0, 0, 0, 0, 0},
         '{MODE_RECT, 8388607, -1, -524288, 0, 0, 0, 0, 0},
         '{MODE_RECT, 25600, 0, 102944, 0, 0, 0, 0, 0},
         '{MODE_RECT, -25600, 0, -205887, 0, 0, 0, 0, 0},
         '{MODE_OFFSET, 0, 0, 0, 0, 0, 0, 0, 0},
         '{MODE_OFFSET, -8388608, -8388608, 0, 8388607, 8388607, 0, 0, 0},
         '{MODE_OFFSET, 8388607, 8388607, 205887, 8388607, 8388607, 0, 0, 0},
         '{MODE_OFFSET, 1000, -1000, -524288, 512, 256, 0, 0, 0},
         '{MODE_OFFSET, 0, 0, 524287, 8388607, 0, 0, 0, 0}
      };
      foreach (rows[i]) begin
         it.mode = rows[i].mode;
         it.cx = 24'(rows[i].cx);
         it.cy = 24'(rows[i].cy);
         it.ang = 20'(rows[i].ang);
         it.w = 23'(rows[i].w);
         it.h = 23'(rows[i].h);
         it.phase = 0;
         if (rows[i].has_exp) begin
            it.e_first = 24'(rows[i].e_first);
            it.e_second = 24'(rows[i].e_second);
         end else begin
            predict_result(it);
         end
         pending_q.push_back(it);
      end
      // random requests in chunks that rotate through the idling phases
      for (int n = 0; n < 1700; n++) begin
         it.mode = mode_type'($urandom_range(99) < 4 ? 3 : $urandom_range(2));
         it.cx = rand_coord();
         it.cy = $urandom_range(9) == 0 ? 24'd0 : rand_coord();
         if (it.mode == MODE_POLAR && $urandom_range(9) == 0) it.cx = '0;
         it.ang = 20'($urandom);
         it.w = rand_size();
         it.h = rand_size();
         it.phase = (n / 100) % 4;
         predict_result(it);
         pending_q.push_back(it);
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (pending_q.size() > 0 || req_tvalid || expected_q.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("[polar_rect_rotate_unit] OK");
      end else begin
         $display("[polar_rect_rotate_unit] ERROR");
      end
      $finish;
   end
endmodule

// File: filelist.f
+incdir+sv
sv/prr_pkg.sv
sv/prr_prep.sv
sv/prr_cordic.sv
sv/prr_post.sv
sv/polar_rect_rotate_unit.sv
sv/prr_checker.sv
dv/polar_rect_rotate_unit_test.sv
